// ===== hdl/ple_pkg.sv =====
// shared types and codes for the positional list engine
package ple_pkg;

  localparam int PLE_CAPACITY    = 32;
  localparam int PLE_VALUE_WIDTH = 32;

  // request actions
  localparam logic [2:0] ACT_INSERT_AT = 3'd0;
  localparam logic [2:0] ACT_REMOVE_AT = 3'd1;
  localparam logic [2:0] ACT_PUSH_BACK = 3'd2;
  localparam logic [2:0] ACT_POP_BACK  = 3'd3;
  localparam logic [2:0] ACT_CLEAR     = 3'd4;
  localparam logic [2:0] ACT_SEARCH    = 3'd5;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_POS   = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic [2:0]         action;
    logic [7:0]         position;
    logic signed [31:0] value;
  } ple_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] found_position;
    logic [5:0] entry_count;
  } ple_rsp_t;

endpackage

// ===== hdl/ple_ram.sv =====
// generic simple dual-port ram, one write and one registered read per cycle
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/positional_list_engine_top.sv =====
// Bounded ordered list of signed values, kept in position order in one ram.
// One request is taken at a time; in_stall stays high until its result has
// been loaded into the output register. An insert or remove moves every
// entry behind the target position by one slot, one entry per cycle through
// the ram's single read port. A search reads entries from the front, one per
// cycle, until it finds the key or runs out of entries. Pop, clear, rejected
// requests and unknown actions go straight to the result. The next request is
// taken as soon as the result is loaded, even while it waits in the output
// register; a result still waiting there holds the following one back.
module positional_list_engine_top import ple_pkg::*; #(
  parameter int CAPACITY    = PLE_CAPACITY,
  parameter int VALUE_WIDTH = PLE_VALUE_WIDTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ple_req_t in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output ple_rsp_t out_data
);

  localparam int IDXW = $clog2(CAPACITY);
  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int WW   = ((CNTW > 8) ? CNTW : 8) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_REM,
    S_SRCH,
    S_RESP
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CNTW-1:0]        cnt_r, cnt_nxt;
  logic [IDXW-1:0]        src_r, src_nxt;
  logic [IDXW-1:0]        dst_r, dst_nxt;
  logic [IDXW-1:0]        idx_r, idx_nxt;
  logic [CNTW-1:0]        rem_r, rem_nxt;
  logic                   pend_r, pend_nxt;
  logic [VALUE_WIDTH-1:0] key_r, key_nxt;
  logic [2:0]             res_status_r, res_status_nxt;
  logic [CNTW-1:0]        res_found_r, res_found_nxt;
  logic                   out_valid_r, out_valid_nxt;
  ple_rsp_t               out_data_r, out_data_nxt;

  logic                   mem_we;
  logic [IDXW-1:0]        mem_waddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic [IDXW-1:0]        mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_rdata;

  ple_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    logic [WW-1:0]    pos_w;
    logic [WW-1:0]    cnt_w;
    logic [WW-1:0]    idx_w;
    logic [WW-1:0]    fnd_w;
    logic signed [63:0] val_sx;

    pos_w  = WW'(in_data.position);
    cnt_w  = WW'(cnt_r);
    idx_w  = '0;
    fnd_w  = WW'(res_found_r);
    val_sx = 64'(in_data.value);

    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    src_nxt        = src_r;
    dst_nxt        = dst_r;
    idx_nxt        = idx_r;
    rem_nxt        = rem_r;
    pend_nxt       = 1'b0;
    key_nxt        = key_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;

    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = key_r;
    mem_raddr = src_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt        = val_sx[VALUE_WIDTH-1:0];
          res_status_nxt = ST_OK;
          res_found_nxt  = '0;
          state_nxt      = S_RESP;
          case (in_data.action)
            ACT_INSERT_AT, ACT_PUSH_BACK: begin
              idx_w = (in_data.action == ACT_PUSH_BACK) ? cnt_w : pos_w - WW'(1);
              if (in_data.action == ACT_INSERT_AT && pos_w == '0) begin
                res_status_nxt = ST_BAD_POS;
              end else if (cnt_w >= WW'(CAPACITY)) begin
                res_status_nxt = ST_FULL;
              end else if (in_data.action == ACT_INSERT_AT && pos_w > cnt_w + WW'(1)) begin
                res_status_nxt = ST_BAD_POS;
              end else begin
                idx_nxt   = IDXW'(idx_w);
                src_nxt   = IDXW'(cnt_w - WW'(1));
                rem_nxt   = CNTW'(cnt_w - idx_w);
                state_nxt = S_INS;
              end
            end
            ACT_REMOVE_AT: begin
              idx_w = pos_w - WW'(1);
              if (pos_w == '0 || pos_w > cnt_w) begin
                res_status_nxt = ST_BAD_POS;
              end else begin
                src_nxt   = IDXW'(pos_w);
                rem_nxt   = CNTW'(cnt_w - WW'(1) - idx_w);
                state_nxt = S_REM;
              end
            end
            ACT_POP_BACK: begin
              if (cnt_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                cnt_nxt = cnt_r - CNTW'(1);
              end
            end
            ACT_CLEAR: begin
              cnt_nxt = '0;
            end
            ACT_SEARCH: begin
              res_status_nxt = ST_NOT_FOUND;
              src_nxt        = '0;
              rem_nxt        = cnt_r;
              state_nxt      = S_SRCH;
            end
            default: begin
            end
          endcase
        end
      end

      // shift entries up one slot from the back toward the insert point
      S_INS: begin
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = dst_r + IDXW'(1);
          mem_wdata = mem_rdata;
        end
        if (rem_r != '0) begin
          mem_raddr = src_r;
          dst_nxt   = src_r;
          src_nxt   = src_r - IDXW'(1);
          rem_nxt   = rem_r - CNTW'(1);
          pend_nxt  = 1'b1;
        end else if (!pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = idx_r;
          mem_wdata = key_r;
          cnt_nxt   = cnt_r + CNTW'(1);
          state_nxt = S_RESP;
        end
      end

      // shift entries down one slot from behind the removed one
      S_REM: begin
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = dst_r - IDXW'(1);
          mem_wdata = mem_rdata;
        end
        if (rem_r != '0) begin
          mem_raddr = src_r;
          dst_nxt   = src_r;
          src_nxt   = src_r + IDXW'(1);
          rem_nxt   = rem_r - CNTW'(1);
          pend_nxt  = 1'b1;
        end else if (!pend_r) begin
          cnt_nxt   = cnt_r - CNTW'(1);
          state_nxt = S_RESP;
        end
      end

      S_SRCH: begin
        if (pend_r && mem_rdata == key_r) begin
          res_status_nxt = ST_OK;
          res_found_nxt  = CNTW'(dst_r) + CNTW'(1);
          state_nxt      = S_RESP;
        end else if (rem_r != '0) begin
          mem_raddr = src_r;
          dst_nxt   = src_r;
          src_nxt   = src_r + IDXW'(1);
          rem_nxt   = rem_r - CNTW'(1);
          pend_nxt  = 1'b1;
        end else if (!pend_r) begin
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.status         = res_status_r;
          out_data_nxt.found_position = fnd_w[5:0];
          out_data_nxt.entry_count    = cnt_w[5:0];
          state_nxt                   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    src_r        <= src_nxt;
    dst_r        <= dst_nxt;
    idx_r        <= idx_nxt;
    rem_r        <= rem_nxt;
    key_r        <= key_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    out_data_r   <= out_data_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(CAPACITY))
    else $error("entry count above capacity");

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (32'(mem_waddr) < CAPACITY && 32'(mem_waddr) <= 32'(cnt_r)))
    else $error("store write outside the live range");

  a_resp_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && !(out_valid_r && out_stall)) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not loaded when output register was free");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.found_position != '0) |-> out_data_r.status == ST_OK)
    else $error("found position reported without ok status");

  a_no_write_search: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH || state_r == S_IDLE || state_r == S_RESP) |-> !mem_we)
    else $error("store written outside a shift");

endmodule

// ===== verif/positional_list_engine_top_tb.sv =====
// self-checking testbench for the positional list engine: directed table plus random requests
module positional_list_engine_top_tb;
  import ple_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 1750;
  localparam int MODE_SPAN    = 80;

  // action codes the block does not define
  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  typedef struct {
    ple_req_t req;
    int       reps;
    bit       typed;
    ple_rsp_t rsp;
  } dir_row_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  ple_req_t in_data;
  logic     out_valid;
  logic     out_stall;
  ple_rsp_t out_data;

  // entries in list order, as the block should hold them
  logic [PLE_VALUE_WIDTH-1:0] list_vals[$];
  ple_rsp_t                   pending_rsp_q[$];
  dir_row_t                   dir_rows[$];

  int send_idle_pct;
  int recv_stall_pct;
  int cycles;
  int err_count;
  int act_count[8];
  int full_hits;
  int search_hits;
  int peak_len;

  positional_list_engine_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // apply one request to the list and return the result it should give
  function automatic ple_rsp_t apply_request(ple_req_t r);
    ple_rsp_t             rsp;
    int                   len;
    int                   pos;
    int                   found;
    logic signed [63:0]   wide;
    logic [PLE_VALUE_WIDTH-1:0] key;
    len   = list_vals.size();
    pos   = r.position;
    found = 0;
    wide  = r.value;
    key   = wide[PLE_VALUE_WIDTH-1:0];
    rsp.status = ST_OK;
    case (r.action)
      ACT_INSERT_AT: begin
        if (pos == 0) rsp.status = ST_BAD_POS;
        else if (len >= PLE_CAPACITY) rsp.status = ST_FULL;
        else if (pos > len + 1) rsp.status = ST_BAD_POS;
        else list_vals.insert(pos - 1, key);
      end
      ACT_REMOVE_AT: begin
        if (pos == 0 || pos > len) rsp.status = ST_BAD_POS;
        else list_vals.delete(pos - 1);
      end
      ACT_PUSH_BACK: begin
        if (len >= PLE_CAPACITY) rsp.status = ST_FULL;
        else list_vals.push_back(key);
      end
      ACT_POP_BACK: begin
        if (len == 0) rsp.status = ST_EMPTY;
        else list_vals.delete(len - 1);
      end
      ACT_CLEAR: begin
        list_vals.delete();
      end
      ACT_SEARCH: begin
        rsp.status = ST_NOT_FOUND;
        for (int k = 0; k < len && found == 0; k++) begin
          if (list_vals[k] == key) begin
            found = k + 1;
            rsp.status = ST_OK;
          end
        end
      end
      default: ;
    endcase
    rsp.found_position = found[5:0];
    len = list_vals.size();
    rsp.entry_count = len[5:0];
    return rsp;
  endfunction

  function automatic dir_row_t mk_row(logic [2:0] act, logic [7:0] pos, logic [31:0] val,
                                      int reps, int typed, logic [2:0] st,
                                      int fpos, int cnt);
    dir_row_t row;
    row.req.action         = act;
    row.req.position       = pos;
    row.req.value          = val;
    row.reps               = reps;
    row.typed              = (typed != 0);
    row.rsp.status         = st;
    row.rsp.found_position = 6'(fpos);
    row.rsp.entry_count    = 6'(cnt);
    return row;
  endfunction

  // random request; grow mode leans on inserts so the store fills up now and then
  function automatic ple_req_t make_request(bit grow);
    ple_req_t r;
    int       len;
    int       pick;
    len  = list_vals.size();
    pick = $urandom_range(0, 99);
    if (grow) begin
      if (pick < 35) r.action = ACT_INSERT_AT;
      else if (pick < 60) r.action = ACT_PUSH_BACK;
      else if (pick < 70) r.action = ACT_REMOVE_AT;
      else if (pick < 75) r.action = ACT_POP_BACK;
      else if (pick < 96) r.action = ACT_SEARCH;
      else r.action = $urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO;
    end else begin
      if (pick < 10) r.action = ACT_INSERT_AT;
      else if (pick < 15) r.action = ACT_PUSH_BACK;
      else if (pick < 45) r.action = ACT_REMOVE_AT;
      else if (pick < 68) r.action = ACT_POP_BACK;
      else if (pick < 95) r.action = ACT_SEARCH;
      else if (pick < 97) r.action = ACT_CLEAR;
      else r.action = $urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO;
    end

    if ($urandom_range(0, 99) < 15) r.position = 8'($urandom_range(0, 255));
    else if (r.action == ACT_INSERT_AT) r.position = 8'($urandom_range(1, len + 1));
    else if (len > 0) r.position = 8'($urandom_range(1, len));
    else r.position = 8'($urandom_range(0, 2));

    // small value pool so searches hit, with full-range values mixed in
    if (r.action == ACT_SEARCH && len > 0 && $urandom_range(0, 1))
      r.value = list_vals[$urandom_range(0, len - 1)];
    else if ($urandom_range(0, 99) < 70)
      r.value = $urandom_range(0, 15) - 8;
    else
      r.value = $urandom();
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    err_count++;
  endtask

  task automatic send_req(ple_req_t r, bit typed, ple_rsp_t typed_rsp);
    ple_rsp_t predicted;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_request(r);
    pending_rsp_q.push_back(typed ? typed_rsp : predicted);
    act_count[r.action]++;
    if (predicted.status == ST_FULL) full_hits++;
    if (r.action == ACT_SEARCH && predicted.status == ST_OK) search_hits++;
    if (list_vals.size() > peak_len) peak_len = list_vals.size();
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    ple_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rsp_q.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing pending (status %0d)",
                                  out_data.status));
      end else begin
        want = pending_rsp_q.pop_front();
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    out_data.status, want.status));
        if (out_data.found_position !== want.found_position)
          report_mismatch($sformatf("found_position got %0d want %0d",
                                    out_data.found_position, want.found_position));
        if (out_data.entry_count !== want.entry_count)
          report_mismatch($sformatf("entry_count got %0d want %0d",
                                    out_data.entry_count, want.entry_count));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_rsp_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    ple_req_t r;
    int       n;
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    cycles         = 0;
    err_count      = 0;
    full_hits      = 0;
    search_hits    = 0;
    peak_len       = 0;
    send_idle_pct  = 9;
    recv_stall_pct = 45;
    foreach (act_count[i]) act_count[i] = 0;

    // empty list, rejected positions, extreme values, full store, unknown action
    dir_rows.push_back(mk_row(ACT_SEARCH,    8'd0,   32'h0,        1, 1, ST_NOT_FOUND, 0, 0));
    dir_rows.push_back(mk_row(ACT_POP_BACK,  8'd0,   32'h0,        1, 1, ST_EMPTY,     0, 0));
    dir_rows.push_back(mk_row(ACT_REMOVE_AT, 8'd0,   32'h0,        1, 1, ST_BAD_POS,   0, 0));
    dir_rows.push_back(mk_row(ACT_REMOVE_AT, 8'd1,   32'h0,        1, 1, ST_BAD_POS,   0, 0));
    dir_rows.push_back(mk_row(ACT_INSERT_AT, 8'd0,   32'h5,        1, 1, ST_BAD_POS,   0, 0));
    dir_rows.push_back(mk_row(ACT_INSERT_AT, 8'd2,   32'h5,        1, 1, ST_BAD_POS,   0, 0));
    dir_rows.push_back(mk_row(ACT_INSERT_AT, 8'd1,   32'h80000000, 1, 1, ST_OK,        0, 1));
    dir_rows.push_back(mk_row(ACT_PUSH_BACK, 8'd0,   32'h7fffffff, 1, 1, ST_OK,        0, 2));
    dir_rows.push_back(mk_row(ACT_INSERT_AT, 8'd3,   32'hffffffff, 1, 0, ST_OK,        0, 0));
    dir_rows.push_back(mk_row(ACT_INSERT_AT, 8'd2,   32'h0,        1, 0, ST_OK,        0, 0));
    dir_rows.push_back(mk_row(ACT_SEARCH,    8'd0,   32'h7fffffff, 1, 0, ST_OK,        0, 0));
    dir_rows.push_back(mk_row(ACT_SEARCH,    8'd0,   32'hffffffff, 1, 0, ST_OK,        0, 0));
    dir_rows.push_back(mk_row(ACT_REMOVE_AT, 8'd4,   32'h0,        1, 0, ST_OK,        0, 0));
    dir_rows.push_back(mk_row(ACT_REMOVE_AT, 8'd255, 32'h0,        1, 0, ST_OK,        0, 0));
    dir_rows.push_back(mk_row(ACT_SPARE_HI,  8'd255, 32'hffffffff, 1, 0, ST_OK,        0, 0));
    dir_rows.push_back(mk_row(ACT_POP_BACK,  8'd0,   32'h0,        1, 0, ST_OK,        0, 0));
    dir_rows.push_back(mk_row(ACT_CLEAR,     8'd0,   32'h0,        1, 1, ST_OK,        0, 0));
    dir_rows.push_back(mk_row(ACT_PUSH_BACK, 8'd0,   32'd100,     PLE_CAPACITY, 0, ST_OK, 0, 0));
    dir_rows.push_back(mk_row(ACT_PUSH_BACK, 8'd0,   32'h1,        1, 1, ST_FULL,      0, 32));
    dir_rows.push_back(mk_row(ACT_INSERT_AT, 8'd0,   32'h1,        1, 1, ST_BAD_POS,   0, 32));
    dir_rows.push_back(mk_row(ACT_INSERT_AT, 8'd1,   32'h1,        1, 1, ST_FULL,      0, 32));
    dir_rows.push_back(mk_row(ACT_INSERT_AT, 8'd255, 32'h1,        1, 1, ST_FULL,      0, 32));
    dir_rows.push_back(mk_row(ACT_SEARCH,    8'd0,   32'd131,      1, 0, ST_OK,        0, 0));
    dir_rows.push_back(mk_row(ACT_REMOVE_AT, 8'd1,   32'h0,        1, 0, ST_OK,        0, 0));
    dir_rows.push_back(mk_row(ACT_INSERT_AT, 8'd32,  32'h80000000, 1, 0, ST_OK,        0, 0));
    dir_rows.push_back(mk_row(ACT_CLEAR,     8'd0,   32'h0,        1, 1, ST_OK,        0, 0));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      for (int rep = 0; rep < dir_rows[i].reps; rep++) begin
        r = dir_rows[i].req;
        r.value = r.value + rep;
        send_req(r, dir_rows[i].typed, dir_rows[i].rsp);
      end
    end

    n = 0;
    while (n < RANDOM_ITEMS) begin
      if (n < RANDOM_ITEMS / 3) begin
        send_idle_pct  = 9;
        recv_stall_pct = 45;
      end else if (n < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct  = 45;
        recv_stall_pct = 9;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      r = make_request(((n / MODE_SPAN) % 2) == 0);
      send_req(r, 1'b0, '0);
      if (r.action <= ACT_SEARCH) n++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (PLE_CAPACITY + 8) @(posedge clk);

    $display("requests: insert %0d remove %0d push %0d pop %0d clear %0d search %0d spare %0d",
             act_count[ACT_INSERT_AT], act_count[ACT_REMOVE_AT], act_count[ACT_PUSH_BACK],
             act_count[ACT_POP_BACK], act_count[ACT_CLEAR], act_count[ACT_SEARCH],
             act_count[ACT_SPARE_LO] + act_count[ACT_SPARE_HI]);
    $display("store full %0d times, %0d searches hit, peak length %0d, %0d mismatches",
             full_hits, search_hits, peak_len, err_count);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
